@@ design/assert_macros.svh @@
// Assertion macros shared by the box filter modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while reset is applied.
`define RCB3_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Same-cycle implication built on the check above.
`define RCB3_ASSERT_IMPLY(lbl, pre, post, msg) \
  `RCB3_ASSERT(lbl, (pre) |-> (post), msg)

`endif

@@ design/rcb3_pkg.sv @@
// Shared types and constants for the circular three-tap row box filter.
package rcb3_pkg;

  localparam int unsigned CHAN_W            = 16;
  localparam int unsigned IDX_W             = 9;
  localparam int unsigned ROW_WIDTH_W       = 10;
  localparam int unsigned MIN_WIDTH         = 3;
  localparam int unsigned MAX_RESULTS       = 3;
  localparam int unsigned FIFO_DEPTH        = 8;
  localparam int unsigned MAX_WIDTH_DFLT    = 512;
  localparam int unsigned CHANNEL_BITS_DFLT = 16;

  localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RST = 10'd512;

  // One input request: previous-row pixel plus the tag of the row being built.
  typedef struct packed {
    logic [IDX_W-1:0]  row_tag;
    logic [CHAN_W-1:0] red_in;
    logic [CHAN_W-1:0] green_in;
    logic [CHAN_W-1:0] blue_in;
  } rcb3_in_t;

  // One result request: an averaged pixel of the next row.
  typedef struct packed {
    logic [IDX_W-1:0]  row_out;
    logic [IDX_W-1:0]  pixel_index;
    logic [CHAN_W-1:0] red_out;
    logic [CHAN_W-1:0] green_out;
    logic [CHAN_W-1:0] blue_out;
    logic              row_done;
  } rcb3_out_t;

  // Bookkeeping that travels beside the lane sums.
  typedef struct packed {
    logic             valid;
    logic [1:0]       count;   // results carried: 1, or 3 on a row close
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] idx;     // pixel index of lane 0
  } rcb3_stage_t;

endpackage

@@ design/rcb3_lane.sv @@
// One averaging lane: registered three-tap sum, then divide by three.
`include "assert_macros.svh"

module rcb3_lane #(
  parameter int unsigned CHANNEL_BITS = rcb3_pkg::CHANNEL_BITS_DFLT
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic [2:0][2:0][((CHANNEL_BITS < rcb3_pkg::CHAN_W) ? CHANNEL_BITS
                           : rcb3_pkg::CHAN_W)-1:0] taps_i,
  output logic [2:0][((CHANNEL_BITS < rcb3_pkg::CHAN_W) ? CHANNEL_BITS
                      : rcb3_pkg::CHAN_W)-1:0] avg_o
);
  import rcb3_pkg::*;

  localparam int unsigned PW = (CHANNEL_BITS < CHAN_W) ? CHANNEL_BITS : CHAN_W;
  localparam int unsigned SW = PW + 2;
  localparam int unsigned K  = SW + 1;
  // ceil(2^K / 3): exact floor division for any sum below 2^SW
  localparam logic [K-2:0] RECIP = (K-1)'(((64'd1 << K) + 64'd2) / 64'd3);

  logic [2:0][SW-1:0]      sum_q;
  logic [2:0][SW-1:0]      sum_d;
  logic [2:0][SW+K-2:0]    prod;

  // Per-channel three-tap sums
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sum_d[c] = SW'(taps_i[0][c]) + SW'(taps_i[1][c]) + SW'(taps_i[2][c]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else if (en_i) begin
      sum_q <= sum_d;
    end
  end

  // Reciprocal multiply replaces the divide by three
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      prod[c]  = sum_q[c] * RECIP;
      avg_o[c] = prod[c][K+PW-1:K];
    end
  end

  // Red channel's quotient of a sum of three channel values must fit one channel
  `RCB3_ASSERT(a_avg_top_zero, prod[0][SW+K-2] == 1'b0, "lane quotient overflow")

endmodule

@@ design/rcb3_ctrl.sv @@
// Row tracking: width register, pixel count, first/recent pixels, lane taps.
`include "assert_macros.svh"

module rcb3_ctrl #(
  parameter int unsigned MAX_WIDTH    = rcb3_pkg::MAX_WIDTH_DFLT,
  parameter int unsigned CHANNEL_BITS = rcb3_pkg::CHANNEL_BITS_DFLT
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [rcb3_pkg::ROW_WIDTH_W-1:0]    cfg_wdata_i,
  input  logic                                acc_i,
  input  rcb3_pkg::rcb3_in_t                  in_data_i,
  output logic [2:0]                          lane_en_o,
  output logic [2:0][2:0][2:0][((CHANNEL_BITS < rcb3_pkg::CHAN_W) ? CHANNEL_BITS
                               : rcb3_pkg::CHAN_W)-1:0] lane_taps_o,
  output rcb3_pkg::rcb3_stage_t               stage_o
);
  import rcb3_pkg::*;

  localparam int unsigned PW    = (CHANNEL_BITS < CHAN_W) ? CHANNEL_BITS : CHAN_W;
  localparam int unsigned CNT_W = $clog2(MAX_WIDTH);
  localparam int unsigned WW    = $clog2(MAX_WIDTH + 1);
  localparam int unsigned CW    = (ROW_WIDTH_W > WW) ? ROW_WIDTH_W : WW;

  logic [ROW_WIDTH_W-1:0]  row_width_q;
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic [CW-1:0]           rw, w_eff;
  logic                    emit, close;
  logic [2:0][PW-1:0]      pix;
  logic [1:0][2:0][PW-1:0] first_q;
  logic [1:0][2:0][PW-1:0] recent_q;
  rcb3_stage_t             stage_q, stage_d;

  // Channel bits above the configured precision are dropped
  assign pix[0] = in_data_i.red_in[PW-1:0];
  assign pix[1] = in_data_i.green_in[PW-1:0];
  assign pix[2] = in_data_i.blue_in[PW-1:0];

  // Effective width, clamped into the supported range
  always_comb begin
    rw = CW'(row_width_q);
    if (rw < CW'(MIN_WIDTH)) begin
      w_eff = CW'(MIN_WIDTH);
    end else if (rw > CW'(MAX_WIDTH)) begin
      w_eff = CW'(MAX_WIDTH);
    end else begin
      w_eff = rw;
    end
  end

  // Result decision for the pixel at position cnt_q
  always_comb begin
    emit  = cnt_q >= CNT_W'(2);
    close = emit && ((CW'(cnt_q) + CW'(1)) >= w_eff);
    cnt_d = close ? '0 : cnt_q + CNT_W'(1);

    stage_d.valid = acc_i && emit;
    stage_d.count = close ? 2'(MAX_RESULTS) : 2'd1;
    stage_d.row   = in_data_i.row_tag;
    stage_d.idx   = IDX_W'(cnt_q - CNT_W'(1));
  end

  // Lane taps: lane 0 -> pixel n-1, lane 1 -> pixel n, lane 2 -> pixel 0
  always_comb begin
    lane_taps_o[0][0] = recent_q[0];
    lane_taps_o[0][1] = recent_q[1];
    lane_taps_o[0][2] = pix;
    lane_taps_o[1][0] = recent_q[1];
    lane_taps_o[1][1] = pix;
    lane_taps_o[1][2] = first_q[0];
    lane_taps_o[2][0] = pix;
    lane_taps_o[2][1] = first_q[0];
    lane_taps_o[2][2] = first_q[1];
    lane_en_o[0]      = acc_i && emit;
    lane_en_o[1]      = acc_i && close;
    lane_en_o[2]      = acc_i && close;
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_width_q <= ROW_WIDTH_RST;
      cnt_q       <= '0;
      stage_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        row_width_q <= cfg_wdata_i;
      end
      if (acc_i) begin
        cnt_q <= cnt_d;
      end
      stage_q <= stage_d;
    end
  end

  // Pixel history
  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      if (cnt_q == CNT_W'(0)) begin
        first_q[0] <= pix;
      end
      if (cnt_q == CNT_W'(1)) begin
        first_q[1] <= pix;
      end
      recent_q[0] <= recent_q[1];
      recent_q[1] <= pix;
    end
  end

  assign stage_o = stage_q;

  `RCB3_ASSERT_IMPLY(a_stage_count, stage_q.valid,
                     (stage_q.count == 2'd1 || stage_q.count == 2'(MAX_RESULTS)),
                     "stage carries an impossible result count")
  `RCB3_ASSERT(a_row_close, (acc_i && close) |=> (cnt_q == '0),
               "pixel count not cleared after row close")
  `RCB3_ASSERT_IMPLY(a_first_silent, acc_i && !emit, !lane_en_o[1] && !lane_en_o[2],
                     "lanes fired on a row's first pixels")

endmodule

@@ design/rcb3_merge.sv @@
// Merge stage: packs lane results in order into an output queue.
`include "assert_macros.svh"

module rcb3_merge #(
  parameter int unsigned CHANNEL_BITS = rcb3_pkg::CHANNEL_BITS_DFLT
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  rcb3_pkg::rcb3_stage_t  stage_i,
  input  logic [2:0][2:0][((CHANNEL_BITS < rcb3_pkg::CHAN_W) ? CHANNEL_BITS
                          : rcb3_pkg::CHAN_W)-1:0] lane_avg_i,
  output logic                   room_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output rcb3_pkg::rcb3_out_t    out_data_o
);
  import rcb3_pkg::*;

  localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned OCC_W = $clog2(FIFO_DEPTH + 1);
  localparam int unsigned SUM_W = OCC_W + 1;

  rcb3_out_t        mem_q [FIFO_DEPTH];
  rcb3_out_t [2:0]  ent;
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [OCC_W-1:0] cnt_q, cnt_d;
  logic [1:0]       push_n;
  logic             pop;

  // Lane results to result records
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      ent[l].row_out   = stage_i.row;
      ent[l].red_out   = CHAN_W'(lane_avg_i[l][0]);
      ent[l].green_out = CHAN_W'(lane_avg_i[l][1]);
      ent[l].blue_out  = CHAN_W'(lane_avg_i[l][2]);
      ent[l].row_done  = 1'b0;
    end
    ent[0].pixel_index = stage_i.idx;
    ent[1].pixel_index = stage_i.idx + IDX_W'(1);
    ent[2].pixel_index = '0;
    ent[2].row_done    = 1'b1;
  end

  // Occupancy and credit
  always_comb begin
    push_n = stage_i.valid ? stage_i.count : 2'd0;
    pop    = out_valid_o && !out_stall_i;
    cnt_d  = cnt_q + OCC_W'(push_n) - OCC_W'(pop);
    room_o = (SUM_W'(cnt_q) + SUM_W'(push_n) + SUM_W'(MAX_RESULTS))
             <= SUM_W'(FIFO_DEPTH);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PTR_W'(push_n);
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
      cnt_q <= cnt_d;
    end
  end

  // Queue storage, up to three writes per cycle in lane order
  always_ff @(posedge clk_i) begin
    for (int j = 0; j < 3; j++) begin
      if (2'(j) < push_n) begin
        mem_q[wr_ptr_q + PTR_W'(j)] <= ent[j];
      end
    end
  end

  assign out_valid_o = cnt_q != '0;
  assign out_data_o  = mem_q[rd_ptr_q];

  `RCB3_ASSERT(a_occ_bound, cnt_q <= OCC_W'(FIFO_DEPTH), "queue overfilled")
  `RCB3_ASSERT_IMPLY(a_credit, stage_i.valid,
                     (SUM_W'(cnt_q) + SUM_W'(stage_i.count)) <= SUM_W'(FIFO_DEPTH),
                     "results in flight exceed queue space")

endmodule

@@ design/row_circular_box3_filter.sv @@
// Top level of the circular three-tap row box filter.
//
//   channel   direction  handshake              payload
//   in        request    in_valid_i/in_stall_o   rcb3_in_t  (one pixel)
//   out       result     out_valid_o/out_stall_i rcb3_out_t (one output pixel)
//   cfg       write      cfg_we_i                cfg_wdata_i (row_width)
//
// One pixel is taken per cycle while in_stall_o is low; the first two pixels
// of a row give nothing, its last pixel gives three results, the rest one each.
// Path from request to result: lane sum register, then the result queue.
// in_stall_o rises when the 8-entry result queue plus the lane stage results
// leave no room for three more; results leave one per cycle unless stalled.
// Reset clears the pixel count, the queue and sets row_width to 512.

module row_circular_box3_filter #(
  parameter int unsigned MAX_WIDTH    = rcb3_pkg::MAX_WIDTH_DFLT,
  parameter int unsigned CHANNEL_BITS = rcb3_pkg::CHANNEL_BITS_DFLT
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [rcb3_pkg::ROW_WIDTH_W-1:0] cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  rcb3_pkg::rcb3_in_t               in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output rcb3_pkg::rcb3_out_t              out_data_o
);
  import rcb3_pkg::*;

  localparam int unsigned PW = (CHANNEL_BITS < CHAN_W) ? CHANNEL_BITS : CHAN_W;

  logic                         acc;
  logic                         room;
  logic [2:0]                   lane_en;
  logic [2:0][2:0][2:0][PW-1:0] lane_taps;
  logic [2:0][2:0][PW-1:0]      lane_avg;
  rcb3_stage_t                  stage;

  assign in_stall_o = !room;
  assign acc        = in_valid_i && !in_stall_o;

  rcb3_ctrl #(
    .MAX_WIDTH    (MAX_WIDTH),
    .CHANNEL_BITS (CHANNEL_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .acc_i       (acc),
    .in_data_i   (in_data_i),
    .lane_en_o   (lane_en),
    .lane_taps_o (lane_taps),
    .stage_o     (stage)
  );

  // Three averaging lanes side by side
  for (genvar l = 0; l < 3; l++) begin : g_lane
    rcb3_lane #(
      .CHANNEL_BITS (CHANNEL_BITS)
    ) u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (lane_en[l]),
      .taps_i (lane_taps[l]),
      .avg_o  (lane_avg[l])
    );
  end

  rcb3_merge #(
    .CHANNEL_BITS (CHANNEL_BITS)
  ) u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .stage_i     (stage),
    .lane_avg_i  (lane_avg),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

@@ sim/row_box3_checker.sv @@
`timescale 1ns / 100ps
// Watches the box filter channels, predicts every averaged pixel and compares the results.
module row_box3_checker #(
  parameter int unsigned MAX_WIDTH = rcb3_pkg::MAX_WIDTH_DFLT
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [rcb3_pkg::ROW_WIDTH_W-1:0] cfg_wdata_i,
  input  logic                             in_valid_i,
  input  logic                             in_stall_i,
  input  rcb3_pkg::rcb3_in_t               in_data_i,
  input  logic                             out_valid_i,
  input  logic                             out_stall_i,
  input  rcb3_pkg::rcb3_out_t              out_data_i,
  output int                               fail_count_o,
  output int                               pending_o
);
  import rcb3_pkg::*;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } rgb_t;

  // Predictor state: row head, sliding window, position and width register
  rgb_t                   head_px [2];
  rgb_t                   window_px [2];
  int unsigned            row_pos;
  logic [ROW_WIDTH_W-1:0] row_width_q;

  // Averaged pixels still owed by the block, oldest first
  rcb3_out_t expected_avg_q [$];
  rcb3_out_t oldest_avg;

  function automatic logic [CHAN_W-1:0] mean3(input logic [CHAN_W-1:0] a, b, c);
    logic [CHAN_W+1:0] sum;
    sum = {2'b00, a} + {2'b00, b} + {2'b00, c};
    return CHAN_W'(sum / 3);
  endfunction

  function automatic rcb3_out_t blend(input logic [IDX_W-1:0] tag, input int unsigned idx,
                                      input rgb_t a, b, c, input logic done);
    rcb3_out_t r;
    r.row_out     = tag;
    r.pixel_index = IDX_W'(idx);
    r.red_out     = mean3(a.red, b.red, c.red);
    r.green_out   = mean3(a.green, b.green, c.green);
    r.blue_out    = mean3(a.blue, b.blue, c.blue);
    r.row_done    = done;
    return r;
  endfunction

  function automatic string show(input rcb3_out_t r);
    return $sformatf("row %0d idx %0d rgb %h %h %h done %b", r.row_out, r.pixel_index,
                     r.red_out, r.green_out, r.blue_out, r.row_done);
  endfunction

  // One accepted pixel: queue the averages it completes and advance the window
  task automatic predict_averages(input rcb3_in_t req);
    rgb_t        px;
    int unsigned w;
    int unsigned n;
    logic        closes;
    px.red   = req.red_in;
    px.green = req.green_in;
    px.blue  = req.blue_in;
    w = row_width_q;
    if (w < MIN_WIDTH) w = MIN_WIDTH;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    n = row_pos;
    closes = (n >= 2) && (n >= w - 1);
    if (n < 2) head_px[n] = px;
    if (n >= 2) begin
      expected_avg_q.push_back(blend(req.row_tag, n - 1, window_px[0], window_px[1], px, 1'b0));
    end
    // Last pixel of the row also yields its own position and the wrapped pixel 0
    if (closes) begin
      expected_avg_q.push_back(blend(req.row_tag, n, window_px[1], px, head_px[0], 1'b0));
      expected_avg_q.push_back(blend(req.row_tag, 0, px, head_px[0], head_px[1], 1'b1));
    end
    window_px[0] = window_px[1];
    window_px[1] = px;
    row_pos = closes ? 0 : n + 1;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_px[0]   = '0;
      head_px[1]   = '0;
      window_px[0] = '0;
      window_px[1] = '0;
      row_pos      = 0;
      row_width_q  = ROW_WIDTH_RST;
      expected_avg_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      // Compare the result leaving the block with the oldest prediction
      if (out_valid_i && !out_stall_i) begin
        if (expected_avg_q.size() == 0) begin
          $display("%0t: result with nothing expected, actual %s", $time, show(out_data_i));
          fail_count_o++;
        end else begin
          oldest_avg = expected_avg_q.pop_front();
          if (out_data_i !== oldest_avg) begin
            $display("%0t: mismatch, expected %s, actual %s", $time, show(oldest_avg),
                     show(out_data_i));
            fail_count_o++;
          end
        end
      end
      if (cfg_we_i) row_width_q = cfg_wdata_i;
      if (in_valid_i && !in_stall_i) predict_averages(in_data_i);
      pending_o = expected_avg_q.size();
    end
  end

endmodule

@@ sim/row_circular_box3_filter_tb.sv @@
`timescale 1ns / 100ps
// Testbench top for the circular three-tap row box filter: pixel stimulus and verdict.
module row_circular_box3_filter_tb;
  import rcb3_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned RANDOM_ITEMS  = 400;

  // Idling regimes: slow sink, slow source, then full rate on both sides
  typedef enum int {PACE_SLOW_SINK, PACE_SLOW_SOURCE, PACE_FULL} pace_e;

  logic                   clk_i       = 1'b0;
  logic                   rst_ni      = 1'b0;
  logic                   cfg_we_i    = 1'b0;
  logic [ROW_WIDTH_W-1:0] cfg_wdata_i = '0;
  logic                   in_valid_i  = 1'b0;
  logic                   in_stall_o;
  rcb3_in_t               in_data_i   = '0;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  rcb3_out_t              out_data_o;

  int          fail_count;
  int          pending;
  int unsigned cycles    = 0;
  pace_e       pace      = PACE_SLOW_SINK;
  // Row position as seen by the source, to keep tags steady along a row
  int unsigned eff_width = MAX_WIDTH_DFLT;
  int unsigned row_pos   = 0;
  logic [IDX_W-1:0] cur_tag = '0;
  int unsigned sent;
  int unsigned burst;

  always #1 clk_i = ~clk_i;

  row_circular_box3_filter dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  row_box3_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_i  (out_data_o),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  // Result backpressure
  always @(negedge clk_i) begin
    out_stall_i <= $urandom_range(0, 99) <
                   ((pace == PACE_SLOW_SINK) ? 81 : (pace == PACE_SLOW_SOURCE) ? 13 : 0);
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("row_circular_box3_filter test failed");
      $finish;
    end
  end

  // Offer one pixel request; returns at the falling edge after it was taken
  task automatic send_pixel(input logic [IDX_W-1:0] tag, input logic [CHAN_W-1:0] r, g, b);
    int unsigned gap_pct;
    logic        taken;
    gap_pct = (pace == PACE_SLOW_SINK) ? 13 : (pace == PACE_SLOW_SOURCE) ? 81 : 0;
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{row_tag: tag, red_in: r, green_in: g, blue_in: b};
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk_i);
      taken = !in_stall_o;
      @(negedge clk_i);
    end
    row_pos = (row_pos >= eff_width - 1) ? 0 : row_pos + 1;
  endtask

  // Drain every owed result, then give the pipeline time to empty
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_width(input logic [ROW_WIDTH_W-1:0] w);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= w;
    @(negedge clk_i);
    cfg_we_i  <= 1'b0;
    eff_width = (w < MIN_WIDTH) ? MIN_WIDTH : (w > MAX_WIDTH_DFLT) ? MAX_WIDTH_DFLT : w;
  endtask

  function automatic logic [CHAN_W-1:0] rand_chan();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return CHAN_W'($urandom);
    endcase
  endfunction

  // Mostly short rows; out-of-range and full widths now and then
  function automatic logic [ROW_WIDTH_W-1:0] pick_width();
    case ($urandom_range(0, 15))
      0:       return 10'd0;
      1:       return 10'd1;
      2:       return 10'd2;
      3:       return 10'd512;
      4:       return 10'd513;
      5:       return 10'd1023;
      default: return ROW_WIDTH_W'($urandom_range(3, 24));
    endcase
  endfunction

  // Steady tag along a row, with an odd stray tag mixed in
  task automatic send_random_pixel();
    logic [IDX_W-1:0] tag;
    if (row_pos == 0) cur_tag = IDX_W'($urandom_range(0, 511));
    tag = ($urandom_range(0, 19) == 0) ? IDX_W'($urandom_range(0, 511)) : cur_tag;
    send_pixel(tag, rand_chan(), rand_chan(), rand_chan());
  endtask

  initial begin
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset width: first two pixels give nothing, then one average each
    pace = PACE_SLOW_SINK;
    send_pixel(9'd0,   16'h0000, 16'h0000, 16'h0000);
    send_pixel(9'd511, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_pixel(9'd0,   16'hAAAA, 16'h5555, 16'hAAAA);
    send_pixel(9'd511, 16'h5555, 16'hAAAA, 16'h5555);
    send_pixel(9'd1,   16'hFFFF, 16'h0000, 16'h0001);

    // Width shrunk mid-row: the next pixel closes the row
    set_width(10'd3);
    send_pixel(9'd2, 16'h0001, 16'h0002, 16'hFFFE);

    // Minimum width, saturated channels then tiny sums
    repeat (3) send_pixel(9'd511, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_pixel(9'd5, 16'h0000, 16'h0000, 16'h0000);
    send_pixel(9'd5, 16'h0000, 16'h0000, 16'h0000);
    send_pixel(9'd5, 16'h0001, 16'h0002, 16'hFFFF);

    // Width below the minimum acts as three
    set_width(10'd0);
    send_pixel(9'd256, 16'h8000, 16'h7FFF, 16'h0003);
    send_pixel(9'd256, 16'h8000, 16'h7FFF, 16'h0003);
    send_pixel(9'd256, 16'h8001, 16'h0001, 16'hFFFF);

    // Tags changing inside one row
    set_width(10'd4);
    send_pixel(9'd7,   16'h1234, 16'hFEDC, 16'h0F0F);
    send_pixel(9'd300, 16'hF0F0, 16'h0123, 16'hCAFE);
    send_pixel(9'd7,   16'hBEEF, 16'h8421, 16'h7BDE);
    send_pixel(9'd1,   16'h0000, 16'hFFFF, 16'h5A5A);

    // Random rows over a range of widths, pacing changing by thirds
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      pace  = (sent < RANDOM_ITEMS / 3)     ? PACE_SLOW_SINK :
              (sent < 2 * RANDOM_ITEMS / 3) ? PACE_SLOW_SOURCE : PACE_FULL;
      set_width(pick_width());
      burst = $urandom_range(4, 40);
      repeat (burst) send_random_pixel();
      sent += burst;
    end

    settle();
    repeat (8) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("row_circular_box3_filter test passed");
    end else begin
      $display("row_circular_box3_filter test failed");
    end
    $finish;
  end

endmodule

@@ row_circular_box3_filter.f @@
+incdir+design
design/rcb3_pkg.sv
design/rcb3_lane.sv
design/rcb3_ctrl.sv
design/rcb3_merge.sv
design/row_circular_box3_filter.sv
sim/row_box3_checker.sv
sim/row_circular_box3_filter_tb.sv
